FILE: design/imhq_pkg.sv
// Package with shared constants and codes for the indexed min-heap queue.
package imhq_pkg;

    localparam int NODES_DEF    = 4096;
    localparam int HEAP_CAP_DEF = 1024;

    localparam int ID_W    = 12;
    localparam int COST_W  = 20;
    localparam int COUNT_W = 10;
    localparam int STAT_W  = 3;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 3'd0,
        ST_KEPT      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

endpackage

FILE: design/imhq_ram.sv
// Simple dual-port memory with one write port and one registered read port.
module imhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue: sequencer, heap and node record memories.
//
// A request (push, pop minimum, remove by id, lookup by id) is taken at a rising edge
// where start is high and busy is low. Busy stays high while the request is worked on.
// Exactly one result follows each request: o_strobe is high for one cycle and the
// status, node record fields and entry count are valid in that cycle. The receiver
// cannot stall; a new request may be started in the cycle the strobe is shown.
// A request takes longer the deeper its sift goes; each sift-down and sift-up level is
// paced by the single read port of the heap memory. A full heap holds 1023 entries.
// A replacing push runs a removal and an insertion back to back.
// Heap entries carry the f key next to the node id so one read gives a slot's key.
// After reset the node record memory is cleared one entry a cycle, all NODES entries, with
// busy held high; the heap is empty after reset.
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int HEAP_CAP = HEAP_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [ID_W-1:0]    i_node_id,
    input  logic [COST_W-1:0]  i_cost_g,
    input  logic [COST_W-1:0]  i_cost_f,
    input  logic [ID_W-1:0]    i_parent_id,
    output logic               o_strobe,
    output logic [STAT_W-1:0]  o_status,
    output logic [ID_W-1:0]    o_out_node,
    output logic [COST_W-1:0]  o_out_g,
    output logic [COST_W-1:0]  o_out_f,
    output logic [ID_W-1:0]    o_out_parent,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int NW = $clog2(NODES);
    localparam int HW = $clog2(HEAP_CAP);
    localparam int XW = HW + 2;

    typedef struct packed {
        logic [NW-1:0]     id;
        logic [COST_W-1:0] key;
    } t_hent;

    typedef struct packed {
        logic              present;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] f;
        logic [ID_W-1:0]   par;
    } t_rec;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_CLR  = 16'h0002,
        S_POPH = 16'h0004,
        S_DEC  = 16'h0008,
        S_DROP = 16'h0010,
        S_LAST = 16'h0020,
        S_SDC  = 16'h0040,
        S_SDL  = 16'h0080,
        S_SDR  = 16'h0100,
        S_SDX  = 16'h0200,
        S_SDE  = 16'h0400,
        S_INS  = 16'h0800,
        S_SUC  = 16'h1000,
        S_SUW  = 16'h2000,
        S_SUP  = 16'h4000,
        S_FIN  = 16'h8000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [NW-1:0]     r_id, n_id;
    logic              r_inr, n_inr;
    logic [COST_W-1:0] r_g, n_g, r_f, n_f;
    logic [ID_W-1:0]   r_par, n_par;
    logic [HW-1:0]     r_fill, n_fill;
    logic [HW-1:0]     r_hole, n_hole;
    logic [HW-1:0]     r_i, n_i;
    logic [HW-1:0]     r_c, n_c;
    t_hent             r_last, n_last;
    t_hent             r_ch, n_ch;
    logic              r_ins, n_ins;
    logic [NW-1:0]     r_clr, n_clr;
    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_onode, n_onode, r_opar, n_opar;
    logic [COST_W-1:0] r_og, n_og, r_of, n_of;
    logic              r_strobe, n_strobe;

    logic          heap_we;
    logic [HW-1:0] heap_waddr, heap_raddr;
    t_hent         heap_wdata, heap_q;
    logic          slot_we;
    logic [NW-1:0] slot_waddr, slot_raddr;
    logic [HW-1:0] slot_wdata, slot_q;
    logic          rec_we;
    logic [NW-1:0] rec_waddr, rec_raddr;
    t_rec          rec_wdata, rec_q;

    logic [XW-1:0] w_child;
    logic [XW-1:0] w_fill_x;
    logic [HW-1:0] w_fill_dec;
    logic [HW-1:0] w_up;

    imhq_ram #(.DEPTH(HEAP_CAP), .WIDTH($bits(t_hent))) u_heap (
        .i_clk  (i_clk),
        .i_we   (heap_we),
        .i_waddr(heap_waddr),
        .i_wdata(heap_wdata),
        .i_raddr(heap_raddr),
        .o_rdata(heap_q)
    );

    imhq_ram #(.DEPTH(NODES), .WIDTH(HW)) u_slot (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_raddr(slot_raddr),
        .o_rdata(slot_q)
    );

    imhq_ram #(.DEPTH(NODES), .WIDTH($bits(t_rec))) u_rec (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(rec_waddr),
        .i_wdata(rec_wdata),
        .i_raddr(rec_raddr),
        .o_rdata(rec_q)
    );

    assign w_child    = XW'({r_i, 1'b1});
    assign w_fill_x   = XW'(r_fill);
    assign w_fill_dec = r_fill - HW'(1);
    assign w_up       = (r_i - HW'(1)) >> 1;

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_id     = r_id;
        n_inr    = r_inr;
        n_g      = r_g;
        n_f      = r_f;
        n_par    = r_par;
        n_fill   = r_fill;
        n_hole   = r_hole;
        n_i      = r_i;
        n_c      = r_c;
        n_last   = r_last;
        n_ch     = r_ch;
        n_ins    = r_ins;
        n_clr    = r_clr;
        n_status = r_status;
        n_onode  = r_onode;
        n_og     = r_og;
        n_of     = r_of;
        n_opar   = r_opar;
        n_strobe = 1'b0;

        heap_we    = 1'b0;
        heap_waddr = r_i;
        heap_wdata = r_last;
        heap_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = r_last.id;
        slot_wdata = r_i;
        slot_raddr = NW'(i_node_id);
        rec_we     = 1'b0;
        rec_waddr  = r_id;
        rec_wdata  = '0;
        rec_raddr  = NW'(i_node_id);

        case (r_state)
            S_CLR: begin
                rec_we    = 1'b1;
                rec_waddr = r_clr;
                rec_wdata = '0;
                n_clr     = r_clr + NW'(1);
                if (r_clr == NW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req    = t_req'(i_req_type);
                    n_id     = NW'(i_node_id);
                    n_inr    = (32'(i_node_id) < NODES);
                    n_g      = i_cost_g;
                    n_f      = i_cost_f;
                    n_par    = i_parent_id;
                    n_ins    = 1'b0;
                    n_status = ST_DONE;
                    n_onode  = '0;
                    n_og     = '0;
                    n_of     = '0;
                    n_opar   = '0;
                    if (t_req'(i_req_type) == REQ_POP) begin
                        if (r_fill == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            heap_raddr = '0;
                            n_state    = S_POPH;
                        end
                    end else begin
                        n_state = S_DEC;
                    end
                end
            end
            S_POPH: begin
                n_id      = heap_q.id;
                rec_raddr = heap_q.id;
                n_state   = S_DEC;
            end
            S_DEC: begin
                n_state = S_FIN;
                if (r_req == REQ_POP) begin
                    n_onode = ID_W'(r_id);
                    n_og    = rec_q.g;
                    n_of    = rec_q.f;
                    n_opar  = rec_q.par;
                    n_hole  = '0;
                    n_state = S_DROP;
                end else if (!r_inr) begin
                    n_status = ST_NOT_FOUND;
                end else if (r_req == REQ_PUSH) begin
                    if (rec_q.present) begin
                        if (r_g < rec_q.g) begin
                            n_ins   = 1'b1;
                            n_hole  = slot_q;
                            n_state = S_DROP;
                        end else begin
                            n_status = ST_KEPT;
                        end
                    end else if (32'(r_fill) + 1 >= HEAP_CAP) begin
                        n_status = ST_FULL;
                    end else begin
                        n_state = S_INS;
                    end
                end else if (rec_q.present) begin
                    if (r_req == REQ_REMOVE) begin
                        n_hole  = slot_q;
                        n_state = S_DROP;
                    end else begin
                        n_onode = ID_W'(r_id);
                        n_og    = rec_q.g;
                        n_of    = rec_q.f;
                        n_opar  = rec_q.par;
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_DROP: begin
                rec_we    = 1'b1;
                rec_waddr = r_id;
                rec_wdata = '0;
                n_fill    = w_fill_dec;
                n_i       = r_hole;
                if (r_hole >= w_fill_dec) begin
                    n_state = r_ins ? S_INS : S_FIN;
                end else begin
                    heap_raddr = w_fill_dec;
                    n_state    = S_LAST;
                end
            end
            S_LAST: begin
                n_last  = heap_q;
                n_state = S_SDC;
            end
            S_SDC: begin
                if (w_child < w_fill_x) begin
                    heap_raddr = HW'(w_child);
                    n_c        = HW'(w_child);
                    n_state    = S_SDL;
                end else begin
                    n_state = S_SDE;
                end
            end
            S_SDL: begin
                n_ch = heap_q;
                if (XW'(r_c) + XW'(1) < w_fill_x) begin
                    heap_raddr = r_c + HW'(1);
                    n_state    = S_SDR;
                end else begin
                    n_state = S_SDX;
                end
            end
            S_SDR: begin
                // The right child wins only on a strictly smaller key.
                if (heap_q.key < r_ch.key) begin
                    n_ch = heap_q;
                    n_c  = r_c + HW'(1);
                end
                n_state = S_SDX;
            end
            S_SDX: begin
                if (r_ch.key < r_last.key) begin
                    heap_we    = 1'b1;
                    heap_waddr = r_i;
                    heap_wdata = r_ch;
                    slot_we    = 1'b1;
                    slot_waddr = r_ch.id;
                    slot_wdata = r_i;
                    n_i        = r_c;
                    n_state    = S_SDC;
                end else begin
                    n_state = S_SDE;
                end
            end
            S_SDE: begin
                // If the last entry did not move down it may still need to move up.
                if (r_i == r_hole) begin
                    n_state = S_SUC;
                end else begin
                    heap_we    = 1'b1;
                    heap_waddr = r_i;
                    heap_wdata = r_last;
                    slot_we    = 1'b1;
                    slot_waddr = r_last.id;
                    slot_wdata = r_i;
                    n_state    = r_ins ? S_INS : S_FIN;
                end
            end
            S_INS: begin
                rec_we    = 1'b1;
                rec_waddr = r_id;
                rec_wdata = '{present: 1'b1, g: r_g, f: r_f, par: r_par};
                n_ins     = 1'b0;
                n_fill    = r_fill + HW'(1);
                n_i       = r_fill;
                n_last    = '{id: r_id, key: r_f};
                n_state   = S_SUC;
            end
            S_SUC: begin
                if (r_i == '0) begin
                    n_state = S_SUP;
                end else begin
                    heap_raddr = w_up;
                    n_c        = w_up;
                    n_state    = S_SUW;
                end
            end
            S_SUW: begin
                if (r_last.key < heap_q.key) begin
                    heap_we    = 1'b1;
                    heap_waddr = r_i;
                    heap_wdata = heap_q;
                    slot_we    = 1'b1;
                    slot_waddr = heap_q.id;
                    slot_wdata = r_i;
                    n_i        = r_c;
                    n_state    = S_SUC;
                end else begin
                    n_state = S_SUP;
                end
            end
            S_SUP: begin
                heap_we    = 1'b1;
                heap_waddr = r_i;
                heap_wdata = r_last;
                slot_we    = 1'b1;
                slot_waddr = r_last.id;
                slot_wdata = r_i;
                n_state    = r_ins ? S_INS : S_FIN;
            end
            S_FIN: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_fill   <= '0;
            r_ins    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_fill   <= n_fill;
            r_ins    <= n_ins;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_id     <= n_id;
        r_inr    <= n_inr;
        r_g      <= n_g;
        r_f      <= n_f;
        r_par    <= n_par;
        r_hole   <= n_hole;
        r_i      <= n_i;
        r_c      <= n_c;
        r_last   <= n_last;
        r_ch     <= n_ch;
        r_status <= n_status;
        r_onode  <= n_onode;
        r_og     <= n_og;
        r_of     <= n_of;
        r_opar   <= n_opar;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_node    = r_onode;
    assign o_out_g       = r_og;
    assign o_out_f       = r_of;
    assign o_out_parent  = r_opar;
    assign o_entry_count = COUNT_W'(r_fill);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < HEAP_CAP)
        else $error("entry count reached heap capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_DONE) |->
            (o_out_node == '0 && o_out_g == '0 && o_out_f == '0 && o_out_parent == '0))
        else $error("failed request carries record data");

endmodule

FILE: tb/sv/tb.sv
// Testbench for the indexed min-heap queue: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb
    import imhq_pkg::*;
();

    typedef struct {
        t_status           status;
        logic [ID_W-1:0]   node;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] f;
        logic [ID_W-1:0]   parent;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    class heap_scoreboard;
        logic [ID_W-1:0]   heap_ids [HEAP_CAP_DEF];
        bit                present  [NODES_DEF];
        int unsigned       slot_of  [NODES_DEF];
        logic [COST_W-1:0] gcost    [NODES_DEF];
        logic [COST_W-1:0] fkey     [NODES_DEF];
        logic [ID_W-1:0]   from_id  [NODES_DEF];
        int unsigned       fill;
        t_outcome          pending [$];
        int                errors;

        function new();
            fill = 0;
            errors = 0;
            foreach (present[n]) present[n] = 1'b0;
        endfunction

        function void place(int unsigned s, logic [ID_W-1:0] id);
            heap_ids[s] = id;
            slot_of[id] = s;
        endfunction

        // The entry only moves past strictly larger keys, so ties keep their order.
        function void sift_up_place(int unsigned s, logic [ID_W-1:0] id);
            logic [COST_W-1:0] k;
            int unsigned up;
            k = fkey[id];
            while (s > 0) begin
                up = (s - 1) >> 1;
                if (k < fkey[heap_ids[up]]) begin
                    place(s, heap_ids[up]);
                    s = up;
                end else begin
                    break;
                end
            end
            place(s, id);
        endfunction

        function void drop_node(logic [ID_W-1:0] id);
            int unsigned hole, i, c;
            logic [ID_W-1:0] last_id;
            logic [COST_W-1:0] k;
            hole = slot_of[id];
            fill--;
            present[id] = 1'b0;
            if (hole >= fill) return;
            last_id = heap_ids[fill];
            k = fkey[last_id];
            i = hole;
            while (2 * i + 1 < fill) begin
                c = 2 * i + 1;
                if (c + 1 < fill && fkey[heap_ids[c + 1]] < fkey[heap_ids[c]]) c = c + 1;
                if (fkey[heap_ids[c]] < k) begin
                    place(i, heap_ids[c]);
                    i = c;
                end else begin
                    break;
                end
            end
            if (i == hole) sift_up_place(hole, last_id);
            else place(i, last_id);
        endfunction

        function void insert_node(logic [ID_W-1:0] id, logic [COST_W-1:0] g,
                                  logic [COST_W-1:0] f, logic [ID_W-1:0] par);
            present[id] = 1'b1;
            gcost[id] = g;
            fkey[id] = f;
            from_id[id] = par;
            fill++;
            sift_up_place(fill - 1, id);
        endfunction

        function void note_request(t_req req, logic [ID_W-1:0] id, logic [COST_W-1:0] g,
                                   logic [COST_W-1:0] f, logic [ID_W-1:0] par);
            t_outcome e;
            logic [ID_W-1:0] top;
            e = '{ST_DONE, '0, '0, '0, '0, '0};
            case (req)
                REQ_POP: begin
                    if (fill == 0) begin
                        e.status = ST_EMPTY;
                    end else begin
                        top = heap_ids[0];
                        e.node = top; e.g = gcost[top]; e.f = fkey[top]; e.parent = from_id[top];
                        drop_node(top);
                    end
                end
                REQ_PUSH: begin
                    if (present[id]) begin
                        if (g < gcost[id]) begin
                            drop_node(id);
                            insert_node(id, g, f, par);
                        end else begin
                            e.status = ST_KEPT;
                        end
                    end else if (fill + 1 >= HEAP_CAP_DEF) begin
                        e.status = ST_FULL;
                    end else begin
                        insert_node(id, g, f, par);
                    end
                end
                REQ_REMOVE: begin
                    if (present[id]) drop_node(id);
                    else e.status = ST_NOT_FOUND;
                end
                default: begin
                    if (present[id]) begin
                        e.node = id; e.g = gcost[id]; e.f = fkey[id]; e.parent = from_id[id];
                    end else begin
                        e.status = ST_NOT_FOUND;
                    end
                end
            endcase
            e.count = fill[COUNT_W-1:0];
            pending.insert(pending.size(), e);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_outcome got);
            t_outcome e;
            if (pending.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.node !== e.node)
                report_mismatch($sformatf("node %0d, expected %0d", got.node, e.node));
            if (got.g !== e.g)
                report_mismatch($sformatf("g %0d, expected %0d", got.g, e.g));
            if (got.f !== e.f)
                report_mismatch($sformatf("f %0d, expected %0d", got.f, e.f));
            if (got.parent !== e.parent)
                report_mismatch($sformatf("parent %0d, expected %0d", got.parent, e.parent));
            if (got.count !== e.count)
                report_mismatch($sformatf("count %0d, expected %0d", got.count, e.count));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_req_type;
    logic [ID_W-1:0]    i_node_id;
    logic [COST_W-1:0]  i_cost_g;
    logic [COST_W-1:0]  i_cost_f;
    logic [ID_W-1:0]    i_parent_id;
    logic               o_strobe;
    logic [STAT_W-1:0]  o_status;
    logic [ID_W-1:0]    o_out_node;
    logic [COST_W-1:0]  o_out_g;
    logic [COST_W-1:0]  o_out_f;
    logic [ID_W-1:0]    o_out_parent;
    logic [COUNT_W-1:0] o_entry_count;

    heap_scoreboard sb;
    bit             quiet_stretch;

    indexed_min_heap_queue u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_node_id(i_node_id), .i_cost_g(i_cost_g),
        .i_cost_f(i_cost_f), .i_parent_id(i_parent_id), .o_strobe(o_strobe),
        .o_status(o_status), .o_out_node(o_out_node), .o_out_g(o_out_g),
        .o_out_f(o_out_f), .o_out_parent(o_out_parent), .o_entry_count(o_entry_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result('{t_status'(o_status), o_out_node, o_out_g, o_out_f,
                              o_out_parent, o_entry_count});
    end

    // Drive one request; start stays high when the next request follows with no gap.
    task send_request(t_req req, logic [ID_W-1:0] id, logic [COST_W-1:0] g,
                      logic [COST_W-1:0] f, logic [ID_W-1:0] par);
        int gap;
        int r;
        r = $urandom_range(99);
        if (quiet_stretch || r < 50) gap = 0;
        else if (r < 90) gap = $urandom_range(3, 1);
        else gap = $urandom_range(40, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_node_id   <= id;
        i_cost_g    <= g;
        i_cost_f    <= f;
        i_parent_id <= par;
        do @(posedge i_clk); while (busy);
        sb.note_request(req, id, g, f, par);
    endtask

    task send_random(int push_pct);
        int r;
        t_req req;
        logic [ID_W-1:0] id;
        logic [COST_W-1:0] g, f;
        r = $urandom_range(99);
        if (r < push_pct) req = REQ_PUSH;
        else if (r < push_pct + (100 - push_pct) / 2) req = REQ_POP;
        else if (r < push_pct + 3 * (100 - push_pct) / 4) req = REQ_REMOVE;
        else req = REQ_LOOKUP;
        r = $urandom_range(99);
        if (r < 55) id = ID_W'($urandom_range(255));
        else if (r < 85) id = ID_W'(2000 + $urandom_range(1029));
        else id = ID_W'($urandom);
        g = ($urandom_range(3) == 0) ? COST_W'($urandom) : COST_W'($urandom_range(4095));
        f = ($urandom_range(3) == 0) ? COST_W'($urandom_range(15)) : COST_W'($urandom);
        send_request(req, id, g, f, ID_W'($urandom));
    endtask

    initial begin
        int k;
        sb = new();
        quiet_stretch = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_PUSH;
        i_node_id = '0;
        i_cost_g = '0;
        i_cost_f = '0;
        i_parent_id = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty pop, absent nodes, field extremes, keep and replace, ties.
        send_request(REQ_POP, 12'd0, '0, '0, '0);
        send_request(REQ_REMOVE, 12'hFFF, '0, '0, '0);
        send_request(REQ_LOOKUP, 12'd0, '0, '0, '0);
        send_request(REQ_PUSH, 12'd0, 20'hFFFFF, 20'hFFFFF, 12'hFFF);
        send_request(REQ_PUSH, 12'hFFF, 20'd0, 20'd0, 12'd0);
        send_request(REQ_LOOKUP, 12'd0, '0, '0, '0);
        send_request(REQ_LOOKUP, 12'hFFF, '0, '0, '0);
        send_request(REQ_PUSH, 12'hFFF, 20'd0, 20'd9, 12'd5);
        send_request(REQ_PUSH, 12'd0, 20'hFFFFF, 20'd1, 12'd1);
        send_request(REQ_PUSH, 12'd0, 20'd100, 20'd5, 12'd7);
        send_request(REQ_PUSH, 12'd1, 20'd3, 20'd5, 12'd2);
        send_request(REQ_PUSH, 12'd2, 20'd3, 20'd5, 12'd3);
        send_request(REQ_PUSH, 12'd3, 20'd3, 20'd5, 12'd4);
        send_request(REQ_PUSH, 12'd4, 20'd8, 20'd2, 12'd4);
        send_request(REQ_REMOVE, 12'd2, '0, '0, '0);
        send_request(REQ_REMOVE, 12'd2, '0, '0, '0);
        send_request(REQ_LOOKUP, 12'd3, '0, '0, '0);
        for (k = 0; k < 5; k++) send_request(REQ_POP, '0, '0, '0, '0);

        // Fill to capacity with distinct nodes so the full case is reached.
        for (k = 0; k < 1030; k++)
            send_request(REQ_PUSH, ID_W'(2000 + k), COST_W'($urandom_range(4095)),
                         COST_W'($urandom), ID_W'($urandom));
        send_request(REQ_PUSH, 12'd2005, 20'd0, 20'd0, 12'd1);
        send_request(REQ_LOOKUP, 12'd2005, '0, '0, '0);

        for (k = 0; k < 900; k++) begin
            if (k % 100 == 0) quiet_stretch = ($urandom_range(3) == 0);
            case ((k / 100) % 4)
                0: send_random(20);
                1: send_random(45);
                2: send_random(60);
                default: send_random(85);
            endcase
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
